>>> design/abic_pkg.sv
package abic_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IDLE_W     = 17;
	localparam int unsigned PROD_W     = 24;
	localparam int unsigned DIV_STEPS  = 8;
	localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

	localparam logic [15:0] RST_OFF_DELAY_MS   = 16'd5000;
	localparam logic [7:0]  RST_MIN_DUTY       = 8'd24;
	localparam logic [7:0]  RST_MAX_DUTY       = 8'd255;
	localparam logic [15:0] RST_AMB_FLOOR      = 16'd1;
	localparam logic [15:0] RST_AMB_CEIL       = 16'd40;
	localparam logic [10:0] RST_PROX_THRESHOLD = 11'd30;
	localparam logic [7:0]  RST_LEVEL          = 8'd180;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFF_DELAY_MS,
		CFG_MIN_DUTY,
		CFG_MAX_DUTY,
		CFG_AMB_FLOOR,
		CFG_AMB_CEIL,
		CFG_PROX_THRESHOLD
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_SAMPLE,
		OP_TOUCH
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CLAMP,
		ST_MUL,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [15:0] off_delay_ms;
		logic [7:0]  min_duty;
		logic [7:0]  max_duty;
		logic [15:0] amb_floor;
		logic [15:0] amb_ceil;
		logic [10:0] prox_threshold;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic clamp;
		logic mul;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_sample;
	} stat_t;

endpackage

>>> design/abic_cfg.sv
module abic_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [abic_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abic_pkg::CFG_DATA_W-1:0] cfg_data,
	output abic_pkg::cfg_t                cfg
);
	import abic_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off_delay_ms   <= RST_OFF_DELAY_MS;
			cfg_q.min_duty       <= RST_MIN_DUTY;
			cfg_q.max_duty       <= RST_MAX_DUTY;
			cfg_q.amb_floor      <= RST_AMB_FLOOR;
			cfg_q.amb_ceil       <= RST_AMB_CEIL;
			cfg_q.prox_threshold <= RST_PROX_THRESHOLD;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_OFF_DELAY_MS:   cfg_q.off_delay_ms   <= cfg_data;
				CFG_MIN_DUTY:       cfg_q.min_duty       <= cfg_data[7:0];
				CFG_MAX_DUTY:       cfg_q.max_duty       <= cfg_data[7:0];
				CFG_AMB_FLOOR:      cfg_q.amb_floor      <= cfg_data;
				CFG_AMB_CEIL:       cfg_q.amb_ceil       <= cfg_data;
				CFG_PROX_THRESHOLD: cfg_q.prox_threshold <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

endmodule

>>> design/abic_ctrl.sv
module abic_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  abic_pkg::stat_t stat,
	output abic_pkg::cmd_t  cmd
);
	import abic_pkg::*;

	state_t             state_q, state_d;
	logic [STEP_W-1:0]  cnt_q;
	logic               out_valid_q;
	logic               slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DECODE;
			ST_DECODE: state_d = stat.is_sample ? ST_CLAMP : ST_FINISH;
			ST_CLAMP:  state_d = ST_MUL;
			ST_MUL:    state_d = ST_DIV;
			ST_DIV:    if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_FINISH;
			ST_FINISH: if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.clamp    = (state_q == ST_CLAMP);
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_FINISH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + STEP_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/abic_dp.sv
module abic_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  abic_pkg::cfg_t  cfg,
	input  abic_pkg::cmd_t  cmd,
	output abic_pkg::stat_t stat,
	input  logic [1:0]      operation,
	input  logic [15:0]     ambient_light,
	input  logic [10:0]     proximity,
	input  logic            usb_present,
	input  logic            animations_busy,
	output logic [7:0]      backlight_duty,
	output logic [7:0]      auto_level,
	output logic            screen_idle,
	output logic            sleep_request
);
	import abic_pkg::*;

	logic [1:0]        op_q;
	logic [15:0]       light_q;
	logic [10:0]       prox_q;
	logic              usb_q, busy_q;

	logic [15:0]       diff_q, span_d_q;
	logic [7:0]        mag_q;
	logic              neg_q, degen_q;
	logic [PROD_W-1:0] rem_q, dv_q;
	logic [7:0]        quo_q;

	logic [IDLE_W-1:0] idle_q, idle_n;
	logic [7:0]        level_q, level_n;
	logic              on_usb_q, on_usb_n;

	logic [7:0]        duty_q, level_out_q;
	logic              idle_out_q, sleep_out_q;

	logic [15:0]       clamped;
	logic              degen;
	logic              ge;
	logic [7:0]        target;
	logic [9:0]        smooth_sum;
	logic              idle_flag;

	assign stat.is_sample = (op_t'(op_q) == OP_SAMPLE);

	assign degen = (cfg.amb_ceil <= cfg.amb_floor);

	always_comb begin
		if (light_q < cfg.amb_floor) begin
			clamped = cfg.amb_floor;
		end else if (light_q > cfg.amb_ceil) begin
			clamped = cfg.amb_ceil;
		end else begin
			clamped = light_q;
		end
	end

	// quotient never exceeds the duty span, so eight restoring steps suffice
	assign ge = (rem_q >= dv_q);

	assign target = degen_q ? cfg.max_duty :
		(neg_q ? cfg.min_duty - quo_q : cfg.min_duty + quo_q);

	assign smooth_sum = {1'b0, level_q, 1'b0} + {2'b0, level_q} + {2'b0, target};

	always_comb begin
		idle_n   = idle_q;
		level_n  = level_q;
		on_usb_n = on_usb_q;
		unique case (op_t'(op_q))
			OP_TICK: begin
				if (idle_q <= {1'b0, cfg.off_delay_ms}) idle_n = idle_q + IDLE_W'(1);
			end
			OP_SAMPLE: begin
				on_usb_n = usb_q;
				level_n  = smooth_sum[9:2];
				if (prox_q > cfg.prox_threshold) idle_n = '0;
			end
			OP_TOUCH: idle_n = '0;
			default: ;
		endcase
	end

	assign idle_flag = (idle_n > {1'b0, cfg.off_delay_ms});

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= operation;
			light_q <= ambient_light;
			prox_q  <= proximity;
			usb_q   <= usb_present;
			busy_q  <= animations_busy;
		end
		if (cmd.clamp) begin
			degen_q  <= degen;
			diff_q   <= clamped - cfg.amb_floor;
			span_d_q <= cfg.amb_ceil - cfg.amb_floor;
			neg_q    <= (cfg.min_duty > cfg.max_duty);
			mag_q    <= (cfg.min_duty > cfg.max_duty) ? cfg.min_duty - cfg.max_duty :
				cfg.max_duty - cfg.min_duty;
		end
		if (cmd.mul) begin
			rem_q <= {8'b0, diff_q} * {16'b0, mag_q};
			dv_q  <= {1'b0, span_d_q, 7'b0};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (ge) rem_q <= rem_q - dv_q;
			quo_q <= {quo_q[6:0], ge};
			dv_q  <= dv_q >> 1;
		end
		if (cmd.finish) begin
			duty_q      <= idle_flag ? 8'd0 : level_n;
			level_out_q <= level_n;
			idle_out_q  <= idle_flag;
			sleep_out_q <= idle_flag && !on_usb_n && !busy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q   <= '0;
			level_q  <= RST_LEVEL;
			on_usb_q <= 1'b1;
		end else if (cmd.finish) begin
			idle_q   <= idle_n;
			level_q  <= level_n;
			on_usb_q <= on_usb_n;
		end
	end

	assign backlight_duty = duty_q;
	assign auto_level     = level_out_q;
	assign screen_idle    = idle_out_q;
	assign sleep_request  = sleep_out_q;

endmodule

>>> design/auto_backlight_idle_control_top.sv
// Backlight duty and idle control.
// Input channel (in_valid/in_ready) takes one item: operation 0 is a 1 ms tick,
// 1 a sensor sample, 2 a touch event; operation 3 only reports current state.
// Output channel (out_valid/out_ready) returns one result per item, in order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while no item is in flight. Unknown indexes are dropped.
// Sequence: a tick, touch or unused item goes from decode to finish;
// a sample goes through decode, clamp, a 16x8 multiply, then an 8-step restoring
// divide (one quotient bit per cycle) for the light-to-duty map, then finish.
// The next item is accepted in the cycle after the result is loaded; only one
// item is in flight at a time.
// The result sits in an output register; a stalled receiver blocks only the
// finishing step of the following item, which then waits in place.
// Reset clears the idle timer, sets the auto level to 180, assumes USB present
// and restores the default register values.
module auto_backlight_idle_control_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      operation,
	input  logic [15:0]                     ambient_light,
	input  logic [10:0]                     proximity,
	input  logic                            usb_present,
	input  logic                            animations_busy,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      backlight_duty,
	output logic [7:0]                      auto_level,
	output logic                            screen_idle,
	output logic                            sleep_request,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [abic_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abic_pkg::CFG_DATA_W-1:0] cfg_data
);
	import abic_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	abic_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	abic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	abic_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.stat            (stat),
		.operation       (operation),
		.ambient_light   (ambient_light),
		.proximity       (proximity),
		.usb_present     (usb_present),
		.animations_busy (animations_busy),
		.backlight_duty  (backlight_duty),
		.auto_level      (auto_level),
		.screen_idle     (screen_idle),
		.sleep_request   (sleep_request)
	);

endmodule

>>> design/abic_checker.sv
module abic_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] backlight_duty,
	input logic [7:0] auto_level,
	input logic       screen_idle,
	input logic       sleep_request
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(backlight_duty)
			&& $stable(auto_level) && $stable(screen_idle) && $stable(sleep_request))
		else $error("result changed while stalled");

	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (screen_idle ? (backlight_duty == 8'd0) : (backlight_duty == auto_level)))
		else $error("duty does not follow idle flag and auto level");

	a_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sleep_request |-> screen_idle)
		else $error("sleep request without idle screen");

	// one item in flight at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transaction");

endmodule

bind auto_backlight_idle_control_top abic_checker u_abic_checker (.*);
